FILE: rtl/scs_pkg.sv
// Shared types and constants for the class score smoothing and top-K block.
// No dependencies; every other file imports this package.
package scs_pkg;

	// Fixed field widths of the ports.
	localparam int SCORE_W = 16;
	localparam int CLS_W = 10;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int COUNT_W = 11;
	localparam int KEEP_W = 4;

	// Defaults for the top-level parameters.
	localparam int MAX_CLASSES_DEF = 1024;
	localparam int MAX_KEEP_DEF = 8;

	// Register reset values.
	localparam logic [COUNT_W-1:0] CLASS_COUNT_RST = COUNT_W'(1000);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT = 2'd3;

	// Command broadcast to every cell of the sorted list.
	typedef struct packed {
		logic insert;
		logic pop;
		logic clear;
	} cell_cmd_t;

endpackage

FILE: rtl/scs_smooth.sv
// Four-stage exponential moving-average pipeline with the per-class score store.
// Depends on scs_pkg.
module scs_smooth import scs_pkg::*; #(
	parameter int MAX_CLASSES = MAX_CLASSES_DEF,
	parameter int IDX_W = $clog2(MAX_CLASSES)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               acc,
	input  logic [SCORE_W-1:0] x,
	input  logic [IDX_W-1:0]   idx,
	input  logic               last,
	input  logic               use_raw,
	input  logic               store_wr,
	input  logic [SCORE_W-1:0] weight,
	output logic               valid_s4,
	output logic [SCORE_W-1:0] conf_s4,
	output logic [IDX_W-1:0]   idx_s4,
	output logic               last_s4
);

	localparam int DIFF_W = SCORE_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int SUM_W = 2 * SCORE_W + 3;
	localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (SCORE_W - 1);

	logic [SCORE_W-1:0] mem [MAX_CLASSES];
	logic [SCORE_W-1:0] rd_q;

	logic valid_s1, valid_s2, valid_s3;
	logic [SCORE_W-1:0] x_s1, x_s2, x_s3;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	logic last_s1, last_s2, last_s3;
	logic raw_s1, raw_s2, raw_s3;
	logic wr_s1, wr_s2, wr_s3, wr_s4;
	logic [SCORE_W-1:0] s_s2, s_s3;
	logic signed [DIFF_W-1:0] diff_s2;
	logic signed [PROD_W-1:0] prod_s3;
	logic signed [SUM_W-1:0] sum_c;
	logic [SCORE_W-1:0] conf_c;

	// Store read at acceptance, write when the new value is known.
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_q <= mem[idx];
		end
		if (valid_s4 && wr_s4) begin
			mem[idx_s4] <= conf_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= acc;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// s + w*(x - s) + one half, scaled back by the weight's fraction bits, or the raw score when raw is set.
	always_comb begin
		sum_c = $signed({3'b000, s_s3, {SCORE_W{1'b0}}}) + SUM_W'(prod_s3) + $signed(HALF);
		conf_c = raw_s3 ? x_s3 : sum_c[2*SCORE_W-1:SCORE_W];
	end

	always_ff @(posedge clk) begin
		x_s1 <= x;
		idx_s1 <= idx;
		last_s1 <= last;
		raw_s1 <= use_raw;
		wr_s1 <= store_wr;

		diff_s2 <= $signed({1'b0, x_s1}) - $signed({1'b0, rd_q});
		s_s2 <= rd_q;
		x_s2 <= x_s1;
		idx_s2 <= idx_s1;
		last_s2 <= last_s1;
		raw_s2 <= raw_s1;
		wr_s2 <= wr_s1;

		prod_s3 <= $signed({1'b0, weight}) * diff_s2;
		s_s3 <= s_s2;
		x_s3 <= x_s2;
		idx_s3 <= idx_s2;
		last_s3 <= last_s2;
		raw_s3 <= raw_s2;
		wr_s3 <= wr_s2;

		conf_s4 <= conf_c;
		idx_s4 <= idx_s3;
		last_s4 <= last_s3;
		wr_s4 <= wr_s3;
	end

endmodule

FILE: rtl/scs_cell.sv
// One entry of the sorted best list: holds, takes the new score, or takes a neighbor's entry.
// Depends on scs_pkg.
module scs_cell import scs_pkg::*; #(
	parameter int IDX_W = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_cmd_t          cmd,
	input  logic [IDX_W-1:0]   new_cls,
	input  logic [SCORE_W-1:0] new_conf,
	input  logic               left_keep,
	input  logic               left_valid,
	input  logic [IDX_W-1:0]   left_cls,
	input  logic [SCORE_W-1:0] left_conf,
	input  logic               right_valid,
	input  logic [IDX_W-1:0]   right_cls,
	input  logic [SCORE_W-1:0] right_conf,
	output logic               keep,
	output logic               valid_q,
	output logic [IDX_W-1:0]   cls_q,
	output logic [SCORE_W-1:0] conf_q
);

	// An entry stays ahead of a new score that is not strictly better.
	assign keep = valid_q && (conf_q >= new_conf);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
		end else if (cmd.insert && !keep) begin
			valid_q <= left_keep ? 1'b1 : left_valid;
		end else if (cmd.pop) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert && !keep) begin
			cls_q <= left_keep ? new_cls : left_cls;
			conf_q <= left_keep ? new_conf : left_conf;
		end else if (cmd.pop) begin
			cls_q <= right_cls;
			conf_q <= right_conf;
		end
	end

endmodule

FILE: rtl/class_score_smoothing_top_k.sv
// Class score smoothing with top-K selection. Scores are taken one per cycle within a frame.
// The last score of a frame closes input until its results are produced: the score runs the
// four-stage smoothing pipeline and then enters the list, and each result is registered from
// the list head while the output is free. Reset clears the configuration registers, the valid
// flags and the control state; data registers and the score store are not cleared, and the
// store is valid only once written.
module class_score_smoothing_top_k import scs_pkg::*; #(
	parameter int MAX_CLASSES = MAX_CLASSES_DEF,
	parameter int MAX_KEEP = MAX_KEEP_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  score_valid,
	output logic                  score_ready,
	input  logic [SCORE_W-1:0]    score,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic                  found,
	output logic [CLS_W-1:0]      class_index,
	output logic [SCORE_W-1:0]    confidence,
	output logic                  rank_last
);

	localparam int IDX_W = $clog2(MAX_CLASSES);
	localparam int CNT_W = IDX_W + 1;
	localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
	localparam int FILL_W = $clog2(MAX_KEEP + 1);
	localparam int KCMP_W = (FILL_W > KEEP_W) ? FILL_W : KEEP_W;

	// Control of a frame: taking scores, waiting for the last score to reach the list,
	// and reading the list out.
	typedef enum logic [2:0] {
		ST_RUN   = 3'b001,
		ST_DRAIN = 3'b010,
		ST_EMIT  = 3'b100
	} state_t;

	state_t state_q;

	logic [SCORE_W-1:0] threshold_q;
	logic [SCORE_W-1:0] weight_q;
	logic [COUNT_W-1:0] class_count_q;
	logic [KEEP_W-1:0] keep_count_q;

	logic [IDX_W-1:0] pos_q;
	logic primed_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] emitted_q;

	logic acc;
	logic frame_end;
	logic [CMP_W-1:0] count_raw;
	logic [CMP_W-1:0] count_eff;
	logic [CMP_W-1:0] pos_next;
	logic weight_on;

	logic valid_s4;
	logic [SCORE_W-1:0] conf_s4;
	logic [IDX_W-1:0] idx_s4;
	logic last_s4;

	cell_cmd_t cmd;
	logic out_free;
	logic emit_load;
	logic emit_done;
	logic emit_last;
	logic [KCMP_W-1:0] keep_ext;
	logic [FILL_W-1:0] keep_eff;
	logic [FILL_W-1:0] emit_n;

	logic cv [MAX_KEEP];
	logic [IDX_W-1:0] ccls [MAX_KEEP];
	logic [SCORE_W-1:0] cconf [MAX_KEEP];
	logic ckeep [MAX_KEEP];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			weight_q <= '0;
			class_count_q <= CLASS_COUNT_RST;
			keep_count_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_THRESHOLD:   threshold_q <= cfg_data;
				CFG_WEIGHT:      weight_q <= cfg_data;
				CFG_CLASS_COUNT: class_count_q <= cfg_data[COUNT_W-1:0];
				CFG_KEEP_COUNT:  keep_count_q <= cfg_data[KEEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Input side. A zero class count acts as one, and a count above the store acts as its
	// depth. The frame ends on the score whose position plus one reaches the count.
	assign score_ready = (state_q == ST_RUN);
	assign acc = score_valid && score_ready;
	assign weight_on = (weight_q != '0);

	always_comb begin
		count_raw = CMP_W'(class_count_q);
		if (count_raw == '0) begin
			count_eff = CMP_W'(1);
		end else if (count_raw > CMP_W'(MAX_CLASSES)) begin
			count_eff = CMP_W'(MAX_CLASSES);
		end else begin
			count_eff = count_raw;
		end
		pos_next = CMP_W'(pos_q) + CMP_W'(1);
		frame_end = (pos_next >= count_eff);
	end

	// The first frame seen with smoothing on only primes the store; the flag is raised
	// once that frame's last score is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			primed_q <= 1'b0;
		end else if (acc) begin
			pos_q <= frame_end ? '0 : IDX_W'(pos_next);
			if (frame_end && weight_on) begin
				primed_q <= 1'b1;
			end
		end
	end

	scs_smooth #(
		.MAX_CLASSES(MAX_CLASSES),
		.IDX_W(IDX_W)
	) u_smooth (
		.clk(clk),
		.arst_n(arst_n),
		.acc(acc),
		.x(score),
		.idx(pos_q),
		.last(frame_end),
		.use_raw(!weight_on || !primed_q),
		.store_wr(weight_on),
		.weight(weight_q),
		.valid_s4(valid_s4),
		.conf_s4(conf_s4),
		.idx_s4(idx_s4),
		.last_s4(last_s4)
	);

	// Sorted list as a row of cells. On insertion every cell compares the new score with
	// its own entry; the first cell whose entry loses takes the new score and the cells
	// behind it each take their left neighbor's entry. The entry pushed off the end is lost.
	// During read-out the row shifts toward the head one place per result.
	assign cmd.insert = valid_s4 && (conf_s4 >= threshold_q);
	assign cmd.pop = emit_load && (emit_n != '0);
	assign cmd.clear = emit_done;

	for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
		logic lkeep;
		logic lv;
		logic [IDX_W-1:0] lcls;
		logic [SCORE_W-1:0] lconf;
		logic rv;
		logic [IDX_W-1:0] rcls;
		logic [SCORE_W-1:0] rconf;

		if (g == 0) begin : g_head
			assign lkeep = 1'b1;
			assign lv = 1'b0;
			assign lcls = idx_s4;
			assign lconf = conf_s4;
		end else begin : g_body
			assign lkeep = ckeep[g-1];
			assign lv = cv[g-1];
			assign lcls = ccls[g-1];
			assign lconf = cconf[g-1];
		end

		if (g == MAX_KEEP - 1) begin : g_tail
			assign rv = 1'b0;
			assign rcls = '0;
			assign rconf = '0;
		end else begin : g_inner
			assign rv = cv[g+1];
			assign rcls = ccls[g+1];
			assign rconf = cconf[g+1];
		end

		scs_cell #(
			.IDX_W(IDX_W)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cmd(cmd),
			.new_cls(idx_s4),
			.new_conf(conf_s4),
			.left_keep(lkeep),
			.left_valid(lv),
			.left_cls(lcls),
			.left_conf(lconf),
			.right_valid(rv),
			.right_cls(rcls),
			.right_conf(rconf),
			.keep(ckeep[g]),
			.valid_q(cv[g]),
			.cls_q(ccls[g]),
			.conf_q(cconf[g])
		);
	end

	// Fill count of the list; a full list keeps its count when a score displaces the tail.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (emit_done) begin
			fill_q <= '0;
		end else if (cmd.insert && (fill_q != FILL_W'(MAX_KEEP))) begin
			fill_q <= fill_q + FILL_W'(1);
		end
	end

	// Read-out. A keep count of zero or above the list size reports the whole list.
	// An empty list gives one not-found result.
	always_comb begin
		keep_ext = KCMP_W'(keep_count_q);
		if ((keep_ext == '0) || (keep_ext > KCMP_W'(MAX_KEEP))) begin
			keep_eff = FILL_W'(MAX_KEEP);
		end else begin
			keep_eff = FILL_W'(keep_count_q);
		end
		emit_n = (fill_q < keep_eff) ? fill_q : keep_eff;
		out_free = !result_valid || result_ready;
		emit_load = (state_q == ST_EMIT) && out_free;
		emit_last = (emit_n == '0) || ((emitted_q + FILL_W'(1)) == emit_n);
		emit_done = emit_load && emit_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			emitted_q <= '0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (acc && frame_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (valid_s4 && last_s4) begin
						state_q <= ST_EMIT;
						emitted_q <= '0;
					end
				end
				ST_EMIT: begin
					if (emit_done) begin
						state_q <= ST_RUN;
					end else if (emit_load) begin
						emitted_q <= emitted_q + FILL_W'(1);
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	// Output register: the next frame's scores are taken while the last result still waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (emit_load) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			rank_last <= emit_last;
			if (emit_n == '0) begin
				found <= 1'b0;
				class_index <= '0;
				confidence <= '0;
			end else begin
				found <= 1'b1;
				class_index <= CLS_W'(ccls[0]);
				confidence <= cconf[0];
			end
		end
	end

endmodule
